// ===== sv/tsc_pkg.sv =====
package tsc_pkg;

    localparam int unsigned SIDE     = 5;
    localparam int unsigned CELLS    = SIDE * SIDE;
    localparam int unsigned ALPHA    = 26;
    localparam int unsigned LETTER_J = 9;

    typedef logic [4:0] t_letter;
    typedef logic [4:0] t_cell;
    typedef logic [2:0] t_row;

    localparam t_letter LAST_LETTER = t_letter'(ALPHA - 1);
    localparam t_letter J_LETTER    = t_letter'(LETTER_J);
    localparam t_cell   FULL_COUNT  = t_cell'(CELLS);
    localparam t_row    LAST_ROW    = t_row'(SIDE - 1);

    typedef enum logic [1:0] {
        ACT_PUSH  = 2'd0,
        ACT_CLOSE = 2'd1,
        ACT_PAIR  = 2'd2,
        ACT_CLEAR = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_SKIPPED   = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PLACE,
        S_CLOSE,
        S_CLEAR,
        S_LOOK,
        S_TARGET,
        S_FETCH,
        S_DONE
    } t_state;

    // sequencer to key store
    typedef struct packed {
        logic    place_en;
        logic    clear_en;
        logic    square;
        t_letter letter;
        t_letter look_a;
        t_letter look_b;
        logic    lookup_en;
        t_cell   tgt_a;
        t_cell   tgt_b;
        logic    read_en;
    } t_store_req;

    // key store to sequencer
    typedef struct packed {
        logic    place_ok;
        logic    present_a;
        logic    present_b;
        t_cell   fill0;
        t_cell   fill1;
        t_cell   cell_a;
        t_cell   cell_b;
        t_letter data_a;
        t_letter data_b;
    } t_store_rsp;

    function automatic t_row cell_row(input t_cell c);
        t_row r;
        if (c >= t_cell'(4 * SIDE))      r = t_row'(4);
        else if (c >= t_cell'(3 * SIDE)) r = t_row'(3);
        else if (c >= t_cell'(2 * SIDE)) r = t_row'(2);
        else if (c >= t_cell'(SIDE))     r = t_row'(1);
        else                             r = t_row'(0);
        return r;
    endfunction

    // row times side, side is 5: row*4 + row
    function automatic t_cell row_base(input t_row r);
        return t_cell'({r, 2'b00}) + t_cell'(r);
    endfunction

    function automatic t_row shift_row(input t_row r, input logic up);
        t_row s;
        if (up) s = (r == t_row'(0)) ? LAST_ROW : r - t_row'(1);
        else    s = (r == LAST_ROW) ? t_row'(0) : r + t_row'(1);
        return s;
    endfunction

endpackage

// ===== sv/two_square_cipher_pair_top.sv =====
// channel   | direction | handshake                  | payload
// ----------+-----------+----------------------------+--------------------------------------
// request   | in        | i_in_valid / o_in_ready    | i_action i_square i_letter_a i_letter_b
// result    | out       | o_out_valid / i_out_ready  | o_out_a o_out_b o_status
// config    | in        | i_cfg_we (no wait)         | i_cfg_wdata (decrypt mode)
//
// one request at a time, one result each; o_in_ready is high only while the sequencer idles
// push and clear are single steps; pair makes two dependent registered table reads (a letter
// not found ends before the first, a target cell beyond the fill count ends after it); close offers
// one letter to the shared placement unit per cycle, a through z
// a finished result moves to the output register as soon as that register is free, so
// the next request is taken while the previous result still waits downstream
// synchronous active-low reset clears control, presence bits, fill counts and decrypt mode
module two_square_cipher_pair_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_action,
    input  logic       i_square,
    input  logic [4:0] i_letter_a,
    input  logic [4:0] i_letter_b,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [4:0] o_out_a,
    output logic [4:0] o_out_b,
    output logic [1:0] o_status
);

    // decrypt mode register
    logic r_decrypt;

    // output register
    logic             r_out_valid;
    tsc_pkg::t_letter r_out_a;
    tsc_pkg::t_letter r_out_b;
    tsc_pkg::t_status r_status;

    // sequencer handshake
    logic             w_idle;
    logic             w_start;
    logic             w_slot_free;
    logic             w_res_valid;
    tsc_pkg::t_letter w_res_a;
    tsc_pkg::t_letter w_res_b;
    tsc_pkg::t_status w_res_status;
    logic             w_load;

    // key store link
    tsc_pkg::t_store_req w_req;
    tsc_pkg::t_store_rsp w_rsp;

    assign o_in_ready  = w_idle;
    assign w_start     = i_in_valid && w_idle;
    // output register free or being drained this cycle
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_load      = w_res_valid && w_slot_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decrypt <= 1'b0;
        end else if (i_cfg_we) begin
            r_decrypt <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_a  <= w_res_a;
            r_out_b  <= w_res_b;
            r_status <= w_res_status;
        end
    end

    tsc_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_decrypt    (r_decrypt),
        .i_start      (w_start),
        .i_action     (tsc_pkg::t_action'(i_action)),
        .i_square     (i_square),
        .i_letter_a   (i_letter_a),
        .i_letter_b   (i_letter_b),
        .i_slot_free  (w_slot_free),
        .o_idle       (w_idle),
        .o_res_valid  (w_res_valid),
        .o_res_a      (w_res_a),
        .o_res_b      (w_res_b),
        .o_res_status (w_res_status),
        .o_req        (w_req),
        .i_rsp        (w_rsp)
    );

    tsc_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_a     = r_out_a;
    assign o_out_b     = r_out_b;
    assign o_status    = r_status;

endmodule

// ===== sv/tsc_store.sv =====
module tsc_store (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tsc_pkg::t_store_req i_req,
    output tsc_pkg::t_store_rsp o_rsp
);

    // letters by cell and cell by letter, one array per square
    tsc_pkg::t_letter r_sq0   [tsc_pkg::CELLS];
    tsc_pkg::t_letter r_sq1   [tsc_pkg::CELLS];
    tsc_pkg::t_cell   r_lcell0[tsc_pkg::ALPHA];
    tsc_pkg::t_cell   r_lcell1[tsc_pkg::ALPHA];

    logic [tsc_pkg::ALPHA-1:0] r_present[2];
    tsc_pkg::t_cell            r_fill[2];

    tsc_pkg::t_cell   r_cell_a;
    tsc_pkg::t_cell   r_cell_b;
    tsc_pkg::t_letter r_data_a;
    tsc_pkg::t_letter r_data_b;

    // presence padded to 32 so any 5-bit letter indexes it
    logic [31:0]    w_pres_sel;
    logic [31:0]    w_pres0;
    logic [31:0]    w_pres1;
    tsc_pkg::t_cell w_fill_sel;
    logic           w_place_ok;

    assign w_pres0    = {{(32 - tsc_pkg::ALPHA){1'b0}}, r_present[0]};
    assign w_pres1    = {{(32 - tsc_pkg::ALPHA){1'b0}}, r_present[1]};
    assign w_pres_sel = i_req.square ? w_pres1 : w_pres0;
    assign w_fill_sel = r_fill[i_req.square];

    // shared placement check for push and close
    assign w_place_ok = (i_req.letter <= tsc_pkg::LAST_LETTER)
                     && (i_req.letter != tsc_pkg::J_LETTER)
                     && !w_pres_sel[i_req.letter]
                     && (w_fill_sel < tsc_pkg::FULL_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present[0] <= '0;
            r_present[1] <= '0;
            r_fill[0]    <= '0;
            r_fill[1]    <= '0;
        end else if (i_req.clear_en) begin
            r_present[i_req.square] <= '0;
            r_fill[i_req.square]    <= '0;
        end else if (i_req.place_en && w_place_ok) begin
            r_present[i_req.square][i_req.letter] <= 1'b1;
            r_fill[i_req.square] <= w_fill_sel + tsc_pkg::t_cell'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.place_en && w_place_ok) begin
            if (i_req.square) begin
                r_sq1[w_fill_sel]      <= i_req.letter;
                r_lcell1[i_req.letter] <= w_fill_sel;
            end else begin
                r_sq0[w_fill_sel]      <= i_req.letter;
                r_lcell0[i_req.letter] <= w_fill_sel;
            end
        end
        if (i_req.lookup_en) begin
            r_cell_a <= r_lcell0[i_req.look_a];
            r_cell_b <= r_lcell1[i_req.look_b];
        end
        if (i_req.read_en) begin
            r_data_a <= r_sq0[i_req.tgt_a];
            r_data_b <= r_sq1[i_req.tgt_b];
        end
    end

    assign o_rsp.place_ok  = w_place_ok;
    assign o_rsp.present_a = w_pres0[i_req.look_a];
    assign o_rsp.present_b = w_pres1[i_req.look_b];
    assign o_rsp.fill0     = r_fill[0];
    assign o_rsp.fill1     = r_fill[1];
    assign o_rsp.cell_a    = r_cell_a;
    assign o_rsp.cell_b    = r_cell_b;
    assign o_rsp.data_a    = r_data_a;
    assign o_rsp.data_b    = r_data_b;

endmodule

// ===== sv/tsc_seq.sv =====
module tsc_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_decrypt,
    input  logic                i_start,
    input  tsc_pkg::t_action    i_action,
    input  logic                i_square,
    input  tsc_pkg::t_letter    i_letter_a,
    input  tsc_pkg::t_letter    i_letter_b,
    input  logic                i_slot_free,
    output logic                o_idle,
    output logic                o_res_valid,
    output tsc_pkg::t_letter    o_res_a,
    output tsc_pkg::t_letter    o_res_b,
    output tsc_pkg::t_status    o_res_status,
    output tsc_pkg::t_store_req o_req,
    input  tsc_pkg::t_store_rsp i_rsp
);

    tsc_pkg::t_state  r_state, n_state;
    logic             r_square;
    tsc_pkg::t_letter r_la, r_lb;
    tsc_pkg::t_letter r_scan, n_scan;
    tsc_pkg::t_letter r_res_a, n_res_a;
    tsc_pkg::t_letter r_res_b, n_res_b;
    tsc_pkg::t_status r_res_status, n_res_status;

    // target cells from the looked-up cells
    tsc_pkg::t_row  w_row_a, w_row_b;
    tsc_pkg::t_cell w_base_a, w_base_b, w_col_a, w_col_b;
    tsc_pkg::t_cell w_tgt_a, w_tgt_b;
    logic           w_found;
    logic           w_tgt_ok;

    assign w_row_a  = tsc_pkg::cell_row(i_rsp.cell_a);
    assign w_row_b  = tsc_pkg::cell_row(i_rsp.cell_b);
    assign w_base_a = tsc_pkg::row_base(w_row_a);
    assign w_base_b = tsc_pkg::row_base(w_row_b);
    assign w_col_a  = i_rsp.cell_a - w_base_a;
    assign w_col_b  = i_rsp.cell_b - w_base_b;

    always_comb begin
        if (w_col_a == w_col_b) begin
            w_tgt_a = tsc_pkg::row_base(tsc_pkg::shift_row(w_row_a, i_decrypt)) + w_col_a;
            w_tgt_b = tsc_pkg::row_base(tsc_pkg::shift_row(w_row_b, i_decrypt)) + w_col_b;
        end else begin
            w_tgt_a = w_base_a + w_col_b;
            w_tgt_b = w_base_b + w_col_a;
        end
    end

    assign w_found  = i_rsp.present_a && i_rsp.present_b;
    assign w_tgt_ok = (w_tgt_a < i_rsp.fill0) && (w_tgt_b < i_rsp.fill1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tsc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_square <= i_square;
            r_la     <= i_letter_a;
            r_lb     <= i_letter_b;
        end
        r_scan       <= n_scan;
        r_res_a      <= n_res_a;
        r_res_b      <= n_res_b;
        r_res_status <= n_res_status;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tsc_pkg::S_IDLE: begin
                if (i_start) begin
                    case (i_action)
                        tsc_pkg::ACT_PUSH:  n_state = tsc_pkg::S_PLACE;
                        tsc_pkg::ACT_CLOSE: n_state = tsc_pkg::S_CLOSE;
                        tsc_pkg::ACT_PAIR:  n_state = tsc_pkg::S_LOOK;
                        tsc_pkg::ACT_CLEAR: n_state = tsc_pkg::S_CLEAR;
                        default:            n_state = tsc_pkg::S_IDLE;
                    endcase
                end
            end
            tsc_pkg::S_PLACE: n_state = tsc_pkg::S_DONE;
            tsc_pkg::S_CLEAR: n_state = tsc_pkg::S_DONE;
            tsc_pkg::S_CLOSE: begin
                if (r_scan == tsc_pkg::LAST_LETTER) n_state = tsc_pkg::S_DONE;
            end
            tsc_pkg::S_LOOK:   n_state = w_found ? tsc_pkg::S_TARGET : tsc_pkg::S_DONE;
            tsc_pkg::S_TARGET: n_state = w_tgt_ok ? tsc_pkg::S_FETCH : tsc_pkg::S_DONE;
            tsc_pkg::S_FETCH:  n_state = tsc_pkg::S_DONE;
            tsc_pkg::S_DONE: begin
                if (i_slot_free) n_state = tsc_pkg::S_IDLE;
            end
            default: n_state = tsc_pkg::S_IDLE;
        endcase
    end

    // outputs and datapath updates
    always_comb begin
        o_req           = '0;
        o_req.square    = r_square;
        o_req.letter    = r_la;
        o_req.look_a    = r_la;
        o_req.look_b    = r_lb;
        o_req.tgt_a     = w_tgt_a;
        o_req.tgt_b     = w_tgt_b;
        n_scan          = r_scan;
        n_res_a         = r_res_a;
        n_res_b         = r_res_b;
        n_res_status    = r_res_status;
        o_idle          = 1'b0;
        o_res_valid     = 1'b0;
        case (r_state)
            tsc_pkg::S_IDLE: begin
                o_idle       = 1'b1;
                n_scan       = '0;
                n_res_a      = '0;
                n_res_b      = '0;
                n_res_status = tsc_pkg::ST_DONE;
            end
            tsc_pkg::S_PLACE: begin
                o_req.place_en = 1'b1;
                if (!i_rsp.place_ok) n_res_status = tsc_pkg::ST_SKIPPED;
            end
            tsc_pkg::S_CLOSE: begin
                o_req.place_en = 1'b1;
                o_req.letter   = r_scan;
                n_scan         = r_scan + tsc_pkg::t_letter'(1);
            end
            tsc_pkg::S_CLEAR: begin
                o_req.clear_en = 1'b1;
            end
            tsc_pkg::S_LOOK: begin
                o_req.lookup_en = w_found;
                if (!w_found) n_res_status = tsc_pkg::ST_NOT_FOUND;
            end
            tsc_pkg::S_TARGET: begin
                o_req.read_en = w_tgt_ok;
                if (!w_tgt_ok) n_res_status = tsc_pkg::ST_NOT_FOUND;
            end
            tsc_pkg::S_FETCH: begin
                n_res_a = i_rsp.data_a;
                n_res_b = i_rsp.data_b;
            end
            tsc_pkg::S_DONE: begin
                o_res_valid = 1'b1;
            end
            default: begin
                o_idle = 1'b0;
            end
        endcase
    end

    assign o_res_a      = r_res_a;
    assign o_res_b      = r_res_b;
    assign o_res_status = r_res_status;

endmodule
